// ----- hw/rtl/spi_clock_divider_search_assert.svh -----
// ----------------------------------------------------------------------------
// Serial clock divider search assertion macros
// Shared forms for the concurrent checks on the divider search ports.
// ----------------------------------------------------------------------------
`ifndef SPI_CLOCK_DIVIDER_SEARCH_ASSERT_SVH
`define SPI_CLOCK_DIVIDER_SEARCH_ASSERT_SVH

// Check that is switched off while reset is held.
`define SCDS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that also holds across reset.
`define SCDS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/spi_cds_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial clock divider search package
// Constants, codes and types shared by the divider search and its checker.
// ----------------------------------------------------------------------------
package spi_cds_pkg;

    localparam int unsigned BAUD_W     = 32;
    localparam int unsigned PRESCALE_W = 8;
    localparam int unsigned POSTDIV_W  = 9;
    localparam int unsigned ERR_W      = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CLK_SRC_W  = 3;

    localparam logic [BAUD_W-1:0]     XTAL_HZ        = 32'd12000000;
    localparam logic [BAUD_W-1:0]     CORE_CLK_RESET = 32'd125000000;
    localparam logic [PRESCALE_W-1:0] PRESCALE_MIN   = 8'd2;
    localparam logic [PRESCALE_W-1:0] PRESCALE_MAX   = 8'd254;
    localparam logic [POSTDIV_W-1:0]  POSTDIV_MIN    = 9'd1;
    localparam logic [POSTDIV_W-1:0]  POSTDIV_MAX    = 9'd256;

    localparam logic [CLK_SRC_W-1:0] CLK_SRC_CORE = 3'd0;
    localparam logic [CLK_SRC_W-1:0] CLK_SRC_XTAL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SOURCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLOCK   = 1'b1;

    typedef logic [ERR_W-1:0] t_err_code;

    localparam t_err_code ERR_NONE     = 2'd0;
    localparam t_err_code ERR_TOO_HIGH = 2'd1;
    localparam t_err_code ERR_TOO_LOW  = 2'd2;

endpackage

// ----- hw/rtl/spi_clock_divider_search.sv -----
// ----------------------------------------------------------------------------
// Serial clock divider search
// Finds the even prescaler and the post-divider that bring the peripheral
// clock to the highest serial bit rate not above a requested target.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_target_baud
// result    out        o_out_valid / i_out_stall  o_prescale, o_postdiv,
//                                                 o_actual_baud, o_error_code
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction runs up to 127 prescaler trials and up to 256 post-divider
// trials, then a restoring divider for the resulting rate.
// A target above the clock skips the search and goes straight to the finish state.
// A new transaction is taken as soon as the result is in the output register.
// Reset is synchronous and restores the configuration registers.
// ----------------------------------------------------------------------------
module spi_clock_divider_search
    import spi_cds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BAUD_W-1:0]     i_target_baud,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PRESCALE_W-1:0] o_prescale,
    output logic [POSTDIV_W-1:0]  o_postdiv,
    output logic [BAUD_W-1:0]     o_actual_baud,
    output logic [ERR_W-1:0]      o_error_code,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BAUD_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_POST_INIT,
        S_POST,
        S_DIV_INIT,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                r_state, n_state;
    logic [CLK_SRC_W-1:0]  r_clk_src, n_clk_src;
    logic [BAUD_W-1:0]     r_core_clk, n_core_clk;
    logic [BAUD_W-1:0]     r_clk, n_clk;
    logic [BAUD_W-1:0]     r_tgt, n_tgt;
    logic [PRESCALE_W-1:0] r_p, n_p;
    logic [POSTDIV_W-1:0]  r_d, n_d;
    logic [39:0]           r_acc, n_acc;
    logic [39:0]           r_step, n_step;
    logic [47:0]           r_prod, n_prod;
    logic [15:0]           r_div, n_div;
    logic [BAUD_W-1:0]     r_quo, n_quo;
    logic [15:0]           r_rem, n_rem;
    logic [4:0]            r_cnt, n_cnt;
    t_err_code             r_err, n_err;
    logic                  r_out_valid, n_out_valid;
    logic [PRESCALE_W-1:0] r_o_p, n_o_p;
    logic [POSTDIV_W-1:0]  r_o_d, n_o_d;
    logic [BAUD_W-1:0]     r_o_rate, n_o_rate;
    t_err_code             r_o_err, n_o_err;

    logic [BAUD_W-1:0] w_peri_clk;
    logic [39:0]       w_tgt2;
    logic [39:0]       w_inc2;
    logic [16:0]       w_pd;
    logic [16:0]       w_rem_sh;
    logic              w_in_acc;

    always_comb begin
        case (r_clk_src)
            CLK_SRC_CORE: w_peri_clk = r_core_clk;
            CLK_SRC_XTAL: w_peri_clk = XTAL_HZ;
            default:      w_peri_clk = '0;
        endcase
    end

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);
    assign w_tgt2   = {7'b0, r_tgt, 1'b0};
    assign w_inc2   = {6'b0, ({1'b0, r_tgt} + 33'd1), 1'b0};
    assign w_pd     = {9'b0, r_p} * {8'b0, r_d};
    assign w_rem_sh = {r_rem, r_quo[BAUD_W-1]};

    always_comb begin
        n_state     = r_state;
        n_clk_src   = r_clk_src;
        n_core_clk  = r_core_clk;
        n_clk       = r_clk;
        n_tgt       = r_tgt;
        n_p         = r_p;
        n_d         = r_d;
        n_acc       = r_acc;
        n_step      = r_step;
        n_prod      = r_prod;
        n_div       = r_div;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_o_p       = r_o_p;
        n_o_d       = r_o_d;
        n_o_rate    = r_o_rate;
        n_o_err     = r_o_err;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLOCK_SOURCE: n_clk_src  = i_cfg_data[CLK_SRC_W-1:0];
                CFG_CORE_CLOCK:   n_core_clk = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_clk  = w_peri_clk;
                    n_tgt  = i_target_baud;
                    n_p    = PRESCALE_MIN;
                    n_acc  = {6'b0, i_target_baud, 2'b0};
                    n_step = {6'b0, ({1'b0, i_target_baud} + 33'd1), 1'b0};
                    if (i_target_baud > w_peri_clk) begin
                        n_err   = ERR_TOO_HIGH;
                        n_state = S_FINISH;
                    end else begin
                        n_err   = ERR_NONE;
                        n_state = S_PRE;
                    end
                end
            end
            S_PRE: begin
                if ({16'b0, r_clk[31:8]} < r_acc) begin
                    n_state = S_POST_INIT;
                end else if (r_p == PRESCALE_MAX) begin
                    n_err   = ERR_TOO_LOW;
                    n_state = S_FINISH;
                end else begin
                    n_p    = r_p + 8'd2;
                    n_acc  = r_acc + w_tgt2;
                    n_step = r_step + w_inc2;
                end
            end
            S_POST_INIT: begin
                n_prod  = {r_step, 8'b0} - {8'b0, r_step};
                n_d     = POSTDIV_MAX;
                n_state = S_POST;
            end
            S_POST: begin
                if (({16'b0, r_clk} >= r_prod) || (r_d == POSTDIV_MIN)) begin
                    n_state = S_DIV_INIT;
                end else begin
                    n_d    = r_d - 9'd1;
                    n_prod = r_prod - {8'b0, r_step};
                end
            end
            S_DIV_INIT: begin
                n_div   = w_pd[15:0];
                n_quo   = r_clk;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_rem_sh >= {1'b0, r_div}) begin
                    n_rem = 16'(w_rem_sh - {1'b0, r_div});
                    n_quo = {r_quo[BAUD_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[15:0];
                    n_quo = {r_quo[BAUD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_err     = r_err;
                    if (r_err == ERR_NONE) begin
                        n_o_p    = r_p;
                        n_o_d    = r_d;
                        n_o_rate = r_quo;
                    end else begin
                        n_o_p    = '0;
                        n_o_d    = '0;
                        n_o_rate = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clk_src   <= CLK_SRC_CORE;
            r_core_clk  <= CORE_CLK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clk_src   <= n_clk_src;
            r_core_clk  <= n_core_clk;
            r_out_valid <= n_out_valid;
        end
        r_clk    <= n_clk;
        r_tgt    <= n_tgt;
        r_p      <= n_p;
        r_d      <= n_d;
        r_acc    <= n_acc;
        r_step   <= n_step;
        r_prod   <= n_prod;
        r_div    <= n_div;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_err    <= n_err;
        r_o_p    <= n_o_p;
        r_o_d    <= n_o_d;
        r_o_rate <= n_o_rate;
        r_o_err  <= n_o_err;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_prescale    = r_o_p;
    assign o_postdiv     = r_o_d;
    assign o_actual_baud = r_o_rate;
    assign o_error_code  = r_o_err;
    assign o_cfg_ready   = 1'b1;

endmodule

// ----- hw/rtl/spi_cds_checker.sv -----
// ----------------------------------------------------------------------------
// Serial clock divider search port checker
// Watches the ports of the divider search for result consistency.
// ----------------------------------------------------------------------------
`include "spi_clock_divider_search_assert.svh"

module spi_cds_checker
    import spi_cds_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [PRESCALE_W-1:0] o_prescale,
    input logic [POSTDIV_W-1:0]  o_postdiv,
    input logic [BAUD_W-1:0]     o_actual_baud,
    input logic [ERR_W-1:0]      o_error_code
);

    `SCDS_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_prescale) && $stable(o_postdiv) && $stable(o_actual_baud) && $stable(o_error_code)), "Stalled result changed.")

    `SCDS_ASSERT(a_err_zero, i_clk, i_rst_n, (o_out_valid && (o_error_code != ERR_NONE)) |-> (o_prescale == '0 && o_postdiv == '0 && o_actual_baud == '0), "Error result carries nonzero dividers.")

    `SCDS_ASSERT(a_ok_range, i_clk, i_rst_n, (o_out_valid && (o_error_code == ERR_NONE)) |-> (!o_prescale[0] && o_prescale >= PRESCALE_MIN && o_postdiv >= POSTDIV_MIN && o_postdiv <= POSTDIV_MAX), "Divider out of range.")

    `SCDS_ASSERT(a_err_code, i_clk, i_rst_n, o_out_valid |-> (o_error_code == ERR_NONE || o_error_code == ERR_TOO_HIGH || o_error_code == ERR_TOO_LOW), "Unknown error code.")

    `SCDS_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid, "Result valid after reset.")

endmodule

bind spi_clock_divider_search spi_cds_checker u_spi_cds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_prescale    (o_prescale),
    .o_postdiv     (o_postdiv),
    .o_actual_baud (o_actual_baud),
    .o_error_code  (o_error_code)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial clock divider search testbench
// Sends target bit rates under a series of clock settings. Each result is
// checked against a local model of the prescaler and post-divider search.
// Random gaps and output stalls are applied, except in the quiet stretches.
// ----------------------------------------------------------------------------
module tb;
    import spi_cds_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_CYCLES = 500;
    localparam int unsigned NUM_SETTINGS = 10;

    typedef struct packed {
        logic [PRESCALE_W-1:0] prescale;
        logic [POSTDIV_W-1:0]  postdiv;
        logic [BAUD_W-1:0]     actual_baud;
        t_err_code             error_code;
    } t_divider_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [BAUD_W-1:0]     i_target_baud = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PRESCALE_W-1:0] o_prescale;
    logic [POSTDIV_W-1:0]  o_postdiv;
    logic [BAUD_W-1:0]     o_actual_baud;
    logic [ERR_W-1:0]      o_error_code;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [BAUD_W-1:0]     i_cfg_data = '0;

    logic [CLK_SRC_W-1:0] clk_src = CLK_SRC_CORE;
    logic [BAUD_W-1:0]    core_hz = CORE_CLK_RESET;

    logic [BAUD_W-1:0] pending_targets[$];
    t_divider_result   expected_dividers[$];
    t_divider_result   want;

    bit          quiet = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned n_in_range = 0;
    int unsigned n_above = 0;
    int unsigned n_below = 0;
    int unsigned cfg_writes = 0;

    spi_clock_divider_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_target_baud (i_target_baud),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_prescale    (o_prescale),
        .o_postdiv     (o_postdiv),
        .o_actual_baud (o_actual_baud),
        .o_error_code  (o_error_code),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [BAUD_W-1:0] peri_hz();
        if (clk_src == CLK_SRC_CORE) return core_hz;
        if (clk_src == CLK_SRC_XTAL) return XTAL_HZ;
        return '0;
    endfunction

    function automatic t_divider_result predict_divider(input logic [BAUD_W-1:0] target);
        t_divider_result res;
        logic [63:0]     clk_hz;
        logic [63:0]     tgt;
        logic [63:0]     p;
        logic [63:0]     d;
        logic [63:0]     q;
        logic            found;
        res = '0;
        clk_hz = {32'd0, peri_hz()};
        tgt = {32'd0, target};
        if (tgt > clk_hz) begin
            res.error_code = ERR_TOO_HIGH;
            return res;
        end
        p = PRESCALE_MIN;
        found = 1'b0;
        while (!found && p <= PRESCALE_MAX) begin
            if (clk_hz < (p + 2) * 256 * tgt) begin
                found = 1'b1;
            end else begin
                p = p + 2;
            end
        end
        if (!found) begin
            res.error_code = ERR_TOO_LOW;
            return res;
        end
        d = POSTDIV_MAX;
        while (d > POSTDIV_MIN && clk_hz / (p * (d - 1)) <= tgt) begin
            d = d - 1;
        end
        q = clk_hz / (p * d);
        res.prescale = p[PRESCALE_W-1:0];
        res.postdiv = d[POSTDIV_W-1:0];
        res.actual_baud = q[BAUD_W-1:0];
        res.error_code = ERR_NONE;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one; none at all in quiet stretches.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 200);
    endfunction

    // Targets cluster at the too-low boundary, at the clock itself, and spread
    // logarithmically over the valid range, with some fully random words and some of zero or one.
    function automatic logic [BAUD_W-1:0] pick_target(input logic [BAUD_W-1:0] clk_hz);
        logic [BAUD_W-1:0] t;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            t = $urandom;
        end else if (r < 22) begin
            t = (clk_hz >> 16) + $urandom_range(0, 2);
            if (t != 0 && $urandom_range(0, 1) == 1) t = t - 1;
        end else if (r < 30) begin
            t = clk_hz + $urandom_range(0, 1);
        end else if (r < 34) begin
            t = $urandom_range(0, 1);
        end else begin
            t = clk_hz >> $urandom_range(0, 16);
            t = t - $urandom_range(0, t >> 1);
        end
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BAUD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_CLOCK_SOURCE) begin
            clk_src = data[CLK_SRC_W-1:0];
        end else begin
            core_hz = data;
        end
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_targets.size() != 0 || i_in_valid || expected_dividers.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_dividers.push_back(predict_divider(i_target_baud));
                send_gap = idle_len();
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_targets.size() > 0) begin
                i_target_baud <= pending_targets.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_dividers.size() == 0) begin
                    $error("result transaction with no expected result pending");
                    mismatches++;
                end else begin
                    want = expected_dividers.pop_front();
                    checked++;
                    case (want.error_code)
                        ERR_NONE:     n_in_range++;
                        ERR_TOO_HIGH: n_above++;
                        default:      n_below++;
                    endcase
                    if (o_prescale !== want.prescale) begin
                        $error("prescale: expected %0d, actual %0d", want.prescale, o_prescale);
                        mismatches++;
                    end
                    if (o_postdiv !== want.postdiv) begin
                        $error("postdiv: expected %0d, actual %0d", want.postdiv, o_postdiv);
                        mismatches++;
                    end
                    if (o_actual_baud !== want.actual_baud) begin
                        $error("actual_baud: expected %0d, actual %0d",
                               want.actual_baud, o_actual_baud);
                        mismatches++;
                    end
                    if (o_error_code !== want.error_code) begin
                        $error("error_code: expected %0d, actual %0d",
                               want.error_code, o_error_code);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [CLK_SRC_W-1:0] src_tab[NUM_SETTINGS];
        logic [BAUD_W-1:0]    core_tab[NUM_SETTINGS];
        int unsigned          count_tab[NUM_SETTINGS];
        logic [BAUD_W-1:0]    clk_hz;
        logic [CLK_SRC_W-1:0] spare_src;

        do spare_src = $urandom_range(1, 6); while (spare_src == CLK_SRC_XTAL);
        src_tab  = '{CLK_SRC_CORE, CLK_SRC_XTAL, CLK_SRC_CORE, CLK_SRC_CORE, CLK_SRC_CORE,
                     {CLK_SRC_W{1'b1}}, spare_src, CLK_SRC_CORE, CLK_SRC_XTAL, CLK_SRC_CORE};
        core_tab = '{CORE_CLK_RESET, CORE_CLK_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1,
                     $urandom, $urandom, $urandom, 32'd0, CORE_CLK_RESET};
        count_tab = '{30, 48, 48, 20, 48, 20, 20, 48, 48, 48};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                wait_idle();
                write_reg(CFG_CLOCK_SOURCE, ($urandom & ~32'h7) | src_tab[s]);
                write_reg(CFG_CORE_CLOCK, core_tab[s]);
            end
            quiet = (s == 2 || s == 7);
            clk_hz = peri_hz();
            if (s == 0) begin
                pending_targets.push_back(32'd0);
                pending_targets.push_back(32'd1);
                pending_targets.push_back(clk_hz >> 16);
                pending_targets.push_back((clk_hz >> 16) + 1);
                pending_targets.push_back(32'd9600);
                pending_targets.push_back(32'd115200);
                pending_targets.push_back(32'd1000000);
                pending_targets.push_back(clk_hz >> 1);
                pending_targets.push_back(clk_hz - 1);
                pending_targets.push_back(clk_hz);
                pending_targets.push_back(clk_hz + 1);
                pending_targets.push_back(32'hFFFF_FFFF);
                pending_targets.push_back(32'h8000_0000);
                pending_targets.push_back(32'h5555_5555);
                pending_targets.push_back(32'hAAAA_AAAA);
            end
            for (int n = 0; n < count_tab[s]; n++) begin
                pending_targets.push_back(pick_target(clk_hz));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d divider results under %0d clock settings (%0d register writes).",
                 checked, NUM_SETTINGS, cfg_writes);
        $display("Outcomes: %0d in range, %0d above the clock, %0d below the lowest rate.",
                 n_in_range, n_above, n_below);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
